### rtl/crcc_pkg.sv
`default_nettype none

package crcc_pkg;

  localparam int MAX_POINTS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 24;
  localparam int T_W        = 24;
  localparam int INT_W      = T_W - FRAC_BITS;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int WGT_W      = FRAC_BITS + 5;
  localparam int PROD_W     = COORD_W + WGT_W;
  localparam int PAIR_W     = PROD_W + 2;
  localparam int SUM_W      = PROD_W + 3;
  localparam int DIV_W      = INT_W + CNT_W - 1;

  localparam logic signed [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_BITS;
  localparam logic signed [PAIR_W-1:0] ROUND_HALF = PAIR_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -(SUM_W'(1) << (COORD_W - 1));

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_POS   = 2'd1,
    OP_DERIV = 2'd2
  } op_t;

  // x, y, z packed as three coordinates
  typedef logic [2:0][COORD_W-1:0] point_t;
  typedef logic signed [WGT_W-1:0] weight_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;

  // four restoring steps of value mod count, largest shift first
  function automatic logic [INT_W-1:0] mod_step4(input logic [INT_W-1:0] r,
                                                 input logic [CNT_W-1:0] c,
                                                 input int top);
    logic [INT_W-1:0] rr;
    logic [DIV_W-1:0] d;
    rr = r;
    for (int j = 0; j < 4; j++) begin
      d = DIV_W'(c) << (top - j);
      if (DIV_W'(rr) >= d) begin
        rr = rr - d[INT_W-1:0];
      end
    end
    return rr;
  endfunction

endpackage

`default_nettype wire

### rtl/catmull_rom_closed_curve_eval_top.sv
`default_nettype none

// channel   | handshake                     | payload
// ----------+-------------------------------+--------------------------------------
// cfg       | cfg_valid / cfg_ready         | cfg_data (point_count)
// input     | in_valid / in_stall           | operation, point_index, point_x/y/z,
//           |                               | param_t
// output    | out_valid / out_stall         | out_x, out_y, out_z, is_derivative
//
// seven register stages, one word accepted per cycle while in_stall is low; an evaluate
// passes through every stage and its result lands in the output register
// stages: mod part 1 / mod part 2 + f*f / table read + u2*f / weights / products /
// pair sums / final sum, round and saturate into the output register
// each stage refills as soon as it empties, so bubbles close up under out_stall
// rst clears the valid bits and sets point_count to 16; the point table is not cleared
// loads write the table in stage 2, in order with the evaluates around them

module catmull_rom_closed_curve_eval_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [crcc_pkg::CNT_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          operation,
  input  logic [crcc_pkg::IDX_W-1:0]          point_index,
  input  logic signed [crcc_pkg::COORD_W-1:0] point_x,
  input  logic signed [crcc_pkg::COORD_W-1:0] point_y,
  input  logic signed [crcc_pkg::COORD_W-1:0] point_z,
  input  logic [crcc_pkg::T_W-1:0]            param_t,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [crcc_pkg::COORD_W-1:0] out_x,
  output logic signed [crcc_pkg::COORD_W-1:0] out_y,
  output logic signed [crcc_pkg::COORD_W-1:0] out_z,
  output logic                                is_derivative
);

  // ---------------- configuration ----------------
  logic [crcc_pkg::CNT_W-1:0] point_count;
  logic [crcc_pkg::CNT_W-1:0] cnt_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= crcc_pkg::CNT_W'(crcc_pkg::MAX_POINTS);
    end else if (cfg_valid && cfg_ready) begin
      point_count <= cfg_data;
    end
  end

  always_comb begin
    priority if (point_count == '0) begin
      cnt_eff = crcc_pkg::CNT_W'(1);
    end else if (point_count > crcc_pkg::CNT_W'(crcc_pkg::MAX_POINTS)) begin
      cnt_eff = crcc_pkg::CNT_W'(crcc_pkg::MAX_POINTS);
    end else begin
      cnt_eff = point_count;
    end
  end

  // ---------------- stage handshake ----------------
  logic v1, v2, v3, v4, v5, v6;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
  logic op_known;

  assign rdy7     = !out_valid || !out_stall;
  assign rdy6     = !v6 || rdy7;
  assign rdy5     = !v5 || rdy6;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  assign op_known = (operation == crcc_pkg::OP_LOAD) || (operation == crcc_pkg::OP_POS) ||
                    (operation == crcc_pkg::OP_DERIV);

  // ---------------- stage 1: upper remainder steps ----------------
  logic                          ld1, dv1;
  logic [crcc_pkg::IDX_W-1:0]    idx1;
  crcc_pkg::point_t              pt1;
  logic [crcc_pkg::FRAC_BITS-1:0] frac1;
  logic [crcc_pkg::INT_W-1:0]    rem1;
  logic [crcc_pkg::CNT_W-1:0]    cnt1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid && op_known;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ld1   <= (operation == crcc_pkg::OP_LOAD);
      dv1   <= (operation == crcc_pkg::OP_DERIV);
      idx1  <= point_index;
      pt1   <= {point_z, point_y, point_x};
      frac1 <= param_t[crcc_pkg::FRAC_BITS-1:0];
      rem1  <= crcc_pkg::mod_step4(param_t[crcc_pkg::T_W-1:crcc_pkg::FRAC_BITS], cnt_eff,
                                   crcc_pkg::INT_W - 1);
      cnt1  <= cnt_eff;
    end
  end

  // ---------------- stage 2: segment, f squared ----------------
  logic                           ld2, dv2;
  logic [crcc_pkg::IDX_W-1:0]     idx2;
  crcc_pkg::point_t               pt2;
  logic [crcc_pkg::FRAC_BITS-1:0] frac2, u2_2;
  logic [crcc_pkg::IDX_W-1:0]     seg2;
  logic [crcc_pkg::CNT_W-1:0]     cnt2;
  logic [2*crcc_pkg::FRAC_BITS-1:0] sq1;
  logic [crcc_pkg::INT_W-1:0]     rem_fin;

  assign sq1     = frac1 * frac1;
  assign rem_fin = crcc_pkg::mod_step4(rem1, cnt1, 3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      ld2   <= ld1;
      dv2   <= dv1;
      idx2  <= idx1;
      pt2   <= pt1;
      frac2 <= frac1;
      u2_2  <= sq1[2*crcc_pkg::FRAC_BITS-1:crcc_pkg::FRAC_BITS];
      seg2  <= rem_fin[crcc_pkg::IDX_W-1:0];
      cnt2  <= cnt1;
    end
  end

  // neighbor slots with wrap-around
  logic [crcc_pkg::CNT_W-1:0] nx1, nx2a, nx2b, pv;
  logic [crcc_pkg::IDX_W-1:0] sel [4];

  always_comb begin
    nx1  = crcc_pkg::CNT_W'(seg2) + crcc_pkg::CNT_W'(1);
    if (nx1 >= cnt2) begin
      nx1 = nx1 - cnt2;
    end
    nx2a = crcc_pkg::CNT_W'(seg2) + crcc_pkg::CNT_W'(2);
    if (nx2a >= cnt2) begin
      nx2a = nx2a - cnt2;
    end
    // a single point wraps twice
    nx2b = nx2a;
    if (nx2b >= cnt2) begin
      nx2b = nx2b - cnt2;
    end
    if (seg2 == '0) begin
      pv = cnt2 - crcc_pkg::CNT_W'(1);
    end else begin
      pv = crcc_pkg::CNT_W'(seg2) - crcc_pkg::CNT_W'(1);
    end
    sel[0] = pv[crcc_pkg::IDX_W-1:0];
    sel[1] = seg2;
    sel[2] = nx1[crcc_pkg::IDX_W-1:0];
    sel[3] = nx2b[crcc_pkg::IDX_W-1:0];
  end

  // ---------------- stage 3: table read, f cubed ----------------
  // two copies of the table, two read ports each
  crcc_pkg::point_t mem_a [crcc_pkg::MAX_POINTS];
  crcc_pkg::point_t mem_b [crcc_pkg::MAX_POINTS];

  logic                           dv3;
  logic [crcc_pkg::FRAC_BITS-1:0] frac3, u2_3, u3_3;
  crcc_pkg::point_t               pts3 [4];
  logic [2*crcc_pkg::FRAC_BITS-1:0] cu2;

  assign cu2 = u2_2 * frac2;

  always_ff @(posedge clk) begin
    if (v2 && rdy3 && ld2) begin
      mem_a[idx2] <= pt2;
      mem_b[idx2] <= pt2;
    end
    if (rdy3) begin
      pts3[0] <= mem_a[sel[0]];
      pts3[1] <= mem_a[sel[1]];
      pts3[2] <= mem_b[sel[2]];
      pts3[3] <= mem_b[sel[3]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2 && !ld2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      dv3   <= dv2;
      frac3 <= frac2;
      u2_3  <= u2_2;
      u3_3  <= cu2[2*crcc_pkg::FRAC_BITS-1:crcc_pkg::FRAC_BITS];
    end
  end

  // ---------------- stage 4: basis weights ----------------
  crcc_pkg::weight_t sf, su2, su3;
  crcc_pkg::weight_t w3 [4];
  crcc_pkg::weight_t w4 [4];
  crcc_pkg::point_t  pts4 [4];
  logic              dv4;

  always_comb begin
    sf  = $signed(crcc_pkg::WGT_W'(frac3));
    su2 = $signed(crcc_pkg::WGT_W'(u2_3));
    su3 = $signed(crcc_pkg::WGT_W'(u3_3));
    if (dv3) begin
      w3[0] = crcc_pkg::WGT_W'(-(su2 * 3) + (sf * 4) - crcc_pkg::WGT_ONE);
      w3[1] = crcc_pkg::WGT_W'((su2 * 9) - (sf * 10));
      w3[2] = crcc_pkg::WGT_W'(-(su2 * 9) + (sf * 8) + crcc_pkg::WGT_ONE);
      w3[3] = crcc_pkg::WGT_W'((su2 * 3) - (sf * 2));
    end else begin
      w3[0] = crcc_pkg::WGT_W'(-su3 + (su2 * 2) - sf);
      w3[1] = crcc_pkg::WGT_W'((su3 * 3) - (su2 * 5) + (crcc_pkg::WGT_ONE * 2));
      w3[2] = crcc_pkg::WGT_W'(-(su3 * 3) + (su2 * 4) + sf);
      w3[3] = su3 - su2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      dv4 <= dv3;
      for (int k = 0; k < 4; k++) begin
        w4[k]   <= w3[k];
        pts4[k] <= pts3[k];
      end
    end
  end

  // ---------------- stage 5: products ----------------
  crcc_pkg::prod_t prod5 [3][4];
  logic            dv5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (rdy5) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      dv5 <= dv4;
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 4; k++) begin
          prod5[c][k] <= crcc_pkg::PROD_W'($signed(pts4[k][c])) *
                         crcc_pkg::PROD_W'(w4[k]);
        end
      end
    end
  end

  // ---------------- stage 6: pair sums ----------------
  crcc_pkg::pair_t sa6 [3];
  crcc_pkg::pair_t sb6 [3];
  logic            dv6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (rdy6) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      dv6 <= dv5;
      for (int c = 0; c < 3; c++) begin
        sa6[c] <= crcc_pkg::PAIR_W'(prod5[c][0]) + crcc_pkg::PAIR_W'(prod5[c][1]);
        // half of the final divisor, so the shift rounds the half up
        sb6[c] <= crcc_pkg::PAIR_W'(prod5[c][2]) + crcc_pkg::PAIR_W'(prod5[c][3]) +
                  crcc_pkg::ROUND_HALF;
      end
    end
  end

  // ---------------- stage 7: sum, floor shift, saturate ----------------
  logic signed [crcc_pkg::SUM_W-1:0]   tot [3];
  logic signed [crcc_pkg::SUM_W-1:0]   shr [3];
  logic signed [crcc_pkg::COORD_W-1:0] sat [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      tot[c] = crcc_pkg::SUM_W'(sa6[c]) + crcc_pkg::SUM_W'(sb6[c]);
      shr[c] = tot[c] >>> (crcc_pkg::FRAC_BITS + 1);
      priority if (shr[c] > crcc_pkg::SAT_MAX) begin
        sat[c] = crcc_pkg::SAT_MAX[crcc_pkg::COORD_W-1:0];
      end else if (shr[c] < crcc_pkg::SAT_MIN) begin
        sat[c] = crcc_pkg::SAT_MIN[crcc_pkg::COORD_W-1:0];
      end else begin
        sat[c] = shr[c][crcc_pkg::COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy7) begin
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy7) begin
      out_x         <= sat[0];
      out_y         <= sat[1];
      out_z         <= sat[2];
      is_derivative <= dv6;
    end
  end

  // ---------------- checks ----------------
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (v2 && rdy3 && ld2) |=> !v3)
    else $error("load word reached the arithmetic stages");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (cnt1 != '0 && cnt1 <= crcc_pkg::CNT_W'(crcc_pkg::MAX_POINTS)))
    else $error("point count out of range in stage 1");

  a_seg_below_count: assert property (@(posedge clk) disable iff (rst)
    (v2 && !ld2) |-> (crcc_pkg::CNT_W'(seg2) < cnt2))
    else $error("segment not reduced below point count");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> !in_stall)
    else $error("input stalled with an empty first stage");

endmodule

`default_nettype wire

### tb/sv/crcc_checker.sv
`timescale 1ns / 1ps

module crcc_checker
  import crcc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CNT_W-1:0]          cfg_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [1:0]                operation,
  input  logic [IDX_W-1:0]          point_index,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] point_z,
  input  logic [T_W-1:0]            param_t,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [COORD_W-1:0] out_x,
  input  logic signed [COORD_W-1:0] out_y,
  input  logic signed [COORD_W-1:0] out_z,
  input  logic                      is_derivative,
  output int                        fail_count,
  output int                        curve_pending,
  output int                        curve_checked
);

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      deriv;
  } curve_word_t;

  localparam longint SCALE   = longint'(1) << FRAC_BITS;
  localparam longint CLIP_HI = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint CLIP_LO = -(longint'(1) << (COORD_W - 1));

  logic signed [COORD_W-1:0] coord_tab [MAX_POINTS][3];
  logic [CNT_W-1:0]          count_reg;
  curve_word_t               curve_q [$];
  int                        n_fail;
  int                        n_checked;

  function automatic curve_word_t curve_point(input logic [T_W-1:0] t, input logic deriv);
    int unsigned  cnt;
    int unsigned  seg;
    int unsigned  sel [4];
    longint       f;
    longint       u2;
    longint       u3;
    longint       w [4];
    longint       acc;
    logic signed [COORD_W-1:0] c [3];
    curve_word_t  res;
    cnt = count_reg;
    if (cnt == 0) cnt = 1;
    if (cnt > MAX_POINTS) cnt = MAX_POINTS;
    seg = int'(t[T_W-1:FRAC_BITS]) % cnt;
    sel[0] = (seg + cnt - 1) % cnt;
    sel[1] = seg;
    sel[2] = (seg + 1) % cnt;
    sel[3] = (seg + 2) % cnt;
    f  = longint'(t[FRAC_BITS-1:0]);
    u2 = (f * f) >>> FRAC_BITS;
    u3 = (u2 * f) >>> FRAC_BITS;
    if (!deriv) begin
      w[0] = -u3 + 2 * u2 - f;
      w[1] = 3 * u3 - 5 * u2 + 2 * SCALE;
      w[2] = -3 * u3 + 4 * u2 + f;
      w[3] = u3 - u2;
    end else begin
      w[0] = -3 * u2 + 4 * f - SCALE;
      w[1] = 9 * u2 - 10 * f;
      w[2] = -9 * u2 + 8 * f + SCALE;
      w[3] = 3 * u2 - 2 * f;
    end
    for (int j = 0; j < 3; j++) begin
      acc = SCALE;
      for (int k = 0; k < 4; k++) begin
        acc += longint'(coord_tab[sel[k]][j]) * w[k];
      end
      // weights carry twice the basis, so drop one extra bit; floor rounds half up
      acc = acc >>> (FRAC_BITS + 1);
      if (acc > CLIP_HI) acc = CLIP_HI;
      if (acc < CLIP_LO) acc = CLIP_LO;
      c[j] = acc[COORD_W-1:0];
    end
    res.x = c[0];
    res.y = c[1];
    res.z = c[2];
    res.deriv = deriv;
    return res;
  endfunction

  initial begin
    n_fail = 0;
    n_checked = 0;
    count_reg = MAX_POINTS;
    fail_count = 0;
    curve_pending = 0;
    curve_checked = 0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      for (int j = 0; j < 3; j++) coord_tab[i][j] = '0;
    end
  end

  always @(posedge clk) begin
    curve_word_t exp_w;
    if (rst) begin
      count_reg = MAX_POINTS;
      curve_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) count_reg = cfg_data;
      if (in_valid && !in_stall) begin
        case (operation)
          OP_LOAD: begin
            coord_tab[point_index][0] = point_x;
            coord_tab[point_index][1] = point_y;
            coord_tab[point_index][2] = point_z;
          end
          OP_POS:   curve_q.push_back(curve_point(param_t, 1'b0));
          OP_DERIV: curve_q.push_back(curve_point(param_t, 1'b1));
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (curve_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("unexpected result word: x=%0d y=%0d z=%0d deriv=%0b",
                     out_x, out_y, out_z, is_derivative);
        end else begin
          exp_w = curve_q.pop_front();
          n_checked++;
          if (out_x !== exp_w.x || out_y !== exp_w.y || out_z !== exp_w.z ||
              is_derivative !== exp_w.deriv) begin
            n_fail++;
            if (n_fail <= 10)
              $display("mismatch: expected x=%0d y=%0d z=%0d deriv=%0b, got x=%0d y=%0d z=%0d deriv=%0b",
                       exp_w.x, exp_w.y, exp_w.z, exp_w.deriv,
                       out_x, out_y, out_z, is_derivative);
          end
        end
      end
    end
    fail_count    <= n_fail;
    curve_pending <= curve_q.size();
    curve_checked <= n_checked;
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import crcc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PIPE_LAT = 7;
  localparam int N_SEGS = 8;
  localparam int SEG_WORDS = 138;
  localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;

  logic                      clk;
  logic                      rst;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CNT_W-1:0]          cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                operation;
  logic [IDX_W-1:0]          point_index;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  logic [T_W-1:0]            param_t;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic                      is_derivative;

  int fail_count;
  int curve_pending;
  int curve_checked;

  int send_idle_pct;
  int stall_pct;
  bit hold_req;
  int n_loads;
  int n_pos;
  int n_deriv;
  int n_unused;
  int n_counts;

  catmull_rom_closed_curve_eval_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .point_index   (point_index),
    .point_x       (point_x),
    .point_y       (point_y),
    .point_z       (point_z),
    .param_t       (param_t),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .is_derivative (is_derivative)
  );

  crcc_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .point_index   (point_index),
    .point_x       (point_x),
    .point_y       (point_y),
    .point_z       (point_z),
    .param_t       (param_t),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .is_derivative (is_derivative),
    .fail_count    (fail_count),
    .curve_pending (curve_pending),
    .curve_checked (curve_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL catmull_rom_closed_curve_eval_top");
    $finish;
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic logic signed [COORD_W-1:0] rand_coord();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return C_MAX;
    if (pick < 30) return C_MIN;
    return COORD_W'($urandom);
  endfunction

  function automatic logic [T_W-1:0] rand_param();
    logic [FRAC_BITS-1:0] fr;
    if ($urandom_range(99) < 70) return T_W'($urandom);
    case ($urandom_range(3))
      0: fr = '0;
      1: fr = '1;
      2: fr = FRAC_BITS'(1) << (FRAC_BITS - 1);
      default: fr = FRAC_BITS'(1);
    endcase
    return {INT_W'($urandom), fr};
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                           input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input logic signed [COORD_W-1:0] z,
                           input logic [T_W-1:0] t);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    point_index <= idx;
    point_x     <= x;
    point_y     <= y;
    point_z     <= z;
    param_t     <= t;
    do @(posedge clk); while (in_stall);
    case (op)
      OP_LOAD:  n_loads++;
      OP_POS:   n_pos++;
      OP_DERIV: n_deriv++;
      default:  n_unused++;
    endcase
  endtask

  task automatic eval_word(input logic [1:0] op, input logic [T_W-1:0] t);
    send_word(op, IDX_W'($urandom), rand_coord(), rand_coord(), rand_coord(), t);
  endtask

  // lower valid, let every outstanding word come back, then let the pipe settle
  task automatic drain_block();
    in_valid <= 1'b0;
    // the checker registers its pending count, so wait for it to take in the last accepted word
    @(posedge clk);
    while (curve_pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  task automatic set_point_count(input logic [CNT_W-1:0] v);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_counts++;
  endtask

  task automatic random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15)
      send_word(OP_LOAD, IDX_W'($urandom), rand_coord(), rand_coord(), rand_coord(),
                T_W'($urandom));
    else if (pick < 18)
      eval_word(OP_UNUSED, rand_param());
    else if (pick < 59)
      eval_word(OP_POS, rand_param());
    else
      eval_word(OP_DERIV, rand_param());
  endtask

  initial begin
    logic [CNT_W-1:0] seg_count [N_SEGS];

    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = OP_LOAD;
    point_index = '0;
    point_x = '0;
    point_y = '0;
    point_z = '0;
    param_t = '0;
    out_stall = 1'b0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    n_loads = 0;
    n_pos = 0;
    n_deriv = 0;
    n_unused = 0;
    n_counts = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // fill the whole table first so no evaluate ever reads an unwritten slot;
    // slots 1 and 2 hold the opposite full-scale values to slots 0 and 3 so segment 1 overshoots and clips
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (i < 4)
        send_word(OP_LOAD, IDX_W'(i), (i == 1 || i == 2) ? C_MAX : C_MIN,
                  (i == 1 || i == 2) ? C_MIN : C_MAX, '0, '0);
      else
        send_word(OP_LOAD, IDX_W'(i), rand_coord(), rand_coord(), rand_coord(), '0);
    end
    eval_word(OP_POS, 24'h000000);
    eval_word(OP_POS, 24'h018000);
    eval_word(OP_DERIV, 24'h018000);
    eval_word(OP_DERIV, 24'h020000);
    eval_word(OP_UNUSED, 24'h018000);
    eval_word(OP_POS, 24'hFFFFFF);
    eval_word(OP_DERIV, 24'hFFFFFF);
    eval_word(OP_POS, 24'h00FFFF);

    // zero acts as one point, 31 clips to the table size
    seg_count = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd4, 5'd2, 5'd16, 5'd3};
    seg_count[7] = CNT_W'($urandom_range(3, 15));
    for (int s = 0; s < N_SEGS; s++) begin
      set_point_count(seg_count[s]);
      case (s % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      for (int n = 0; n < SEG_WORDS; n++) begin
        if (s == 0 && n == 20) hold_req = 1'b1;
        random_word();
      end
    end

    send_idle_pct = 0;
    drain_block();
    $display("covered %0d loads, %0d position and %0d derivative evaluations, %0d unused-op words",
             n_loads, n_pos, n_deriv, n_unused);
    $display("over %0d point-count settings; %0d result words compared, %0d failures",
             n_counts, curve_checked, fail_count);
    if (fail_count == 0 && curve_pending == 0) begin
      $display("PASS catmull_rom_closed_curve_eval_top");
    end else begin
      $display("FAIL catmull_rom_closed_curve_eval_top");
    end
    $finish;
  end

endmodule
